// ===== design/cbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_pkg: shared types and constants of the cubic Bezier tessellator
// Widths of coordinates, weights and the accumulator, and the control
// bundle that the sequencer sends to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package cbt_pkg;

    // coordinate and index widths
    localparam int COORD_W = 16;
    localparam int IDX_W   = 6;
    localparam int LG_W    = 3;
    localparam logic [LG_W-1:0] MAX_LG = 3'd6;

    // un = steps - k needs one bit more than the sample index
    localparam int UN_W  = IDX_W + 1;
    // weights sum to steps^3 <= 2^18
    localparam int WGT_W = 3 * IDX_W + 1;
    // product of a weight and an offset coordinate
    localparam int PROD_W = WGT_W + COORD_W;
    // sum of four products plus the rounding half stays below 2^34
    localparam int ACC_W  = 3 * IDX_W + COORD_W;
    // shift amount 3*lg, up to 18
    localparam int SH_W   = 5;

    // control bundle for the MAC unit
    typedef struct packed {
        logic clr;    // preset both accumulators to the rounding half
        logic acc_x;  // add product into x accumulator
        logic acc_y;  // add product into y accumulator
    } t_mac_ctl;

endpackage

// ===== design/cbt_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_mac: shared multiplier with x and y accumulators
// One unsigned multiplier serves both the weight products and the
// weighted coordinate sums; the product is exposed for weight capture.
// ----------------------------------------------------------------------------
module cbt_mac (
    input  logic                             i_clk,
    input  logic [cbt_pkg::WGT_W-1:0]        i_a,
    input  logic [cbt_pkg::COORD_W-1:0]      i_b,
    input  cbt_pkg::t_mac_ctl                i_ctl,
    input  logic [cbt_pkg::ACC_W-1:0]        i_half,
    output logic [cbt_pkg::PROD_W-1:0]       o_prod,
    output logic [cbt_pkg::ACC_W-1:0]        o_acc_x,
    output logic [cbt_pkg::ACC_W-1:0]        o_acc_y
);

    logic [cbt_pkg::ACC_W-1:0] r_acc_x;
    logic [cbt_pkg::ACC_W-1:0] r_acc_y;
    logic [cbt_pkg::ACC_W-1:0] prod_t;

    // the shared multiplier
    assign o_prod = cbt_pkg::PROD_W'(i_a) * cbt_pkg::PROD_W'(i_b);
    assign prod_t = o_prod[cbt_pkg::ACC_W-1:0];

    // accumulators, preset with the rounding half
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc_x <= i_half;
            r_acc_y <= i_half;
        end else begin
            if (i_ctl.acc_x) begin
                r_acc_x <= r_acc_x + prod_t;
            end
            if (i_ctl.acc_y) begin
                r_acc_y <= r_acc_y + prod_t;
            end
        end
    end

    assign o_acc_x = r_acc_x;
    assign o_acc_y = r_acc_y;

endmodule

// ===== design/cubic_bezier_tessellator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator: samples one cubic Bezier segment per request
// Emits points B(k/steps) for k = 0 .. steps-1, steps = 2^log2_steps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one segment P0..P3 in signed Q12.4.
//   Output channel (o_valid/i_ready) returns one point per request, with its
//   sample index and a flag on the final point of the segment.
//   Config channel (i_cfg_valid/o_cfg_ready) writes log2_steps; values above
//   6 act as 6. Write it only while the block is idle.
//   Each point forms the Bernstein weights (S_UU, S_TT, S_W0 .. S_W3), then
//   runs the multiply-accumulate steps on the single shared multiplier
//   (S_MAC), then loads the output register (S_OUT). After the final point
//   the block returns to idle, in which the next segment request is taken;
//   o_ready stays low while a segment runs.
//   The output register lets the next point compute while one waits; a
//   stalled receiver holds the sequencer only when that point is done.
//   Reset (synchronous, active low) returns to idle, drops o_valid and sets
//   log2_steps to 6.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cbt_pkg::LG_W-1:0]            i_cfg_log2_steps,
    // segment input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [cbt_pkg::COORD_W-1:0]  i_start_x,
    input  logic signed [cbt_pkg::COORD_W-1:0]  i_start_y,
    input  logic signed [cbt_pkg::COORD_W-1:0]  i_out_ctrl_x,
    input  logic signed [cbt_pkg::COORD_W-1:0]  i_out_ctrl_y,
    input  logic signed [cbt_pkg::COORD_W-1:0]  i_in_ctrl_x,
    input  logic signed [cbt_pkg::COORD_W-1:0]  i_in_ctrl_y,
    input  logic signed [cbt_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [cbt_pkg::COORD_W-1:0]  i_end_y,
    // point output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [cbt_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [cbt_pkg::COORD_W-1:0]  o_point_y,
    output logic [cbt_pkg::IDX_W-1:0]           o_sample_index,
    output logic                                o_last_point
);

    localparam int CW = cbt_pkg::COORD_W;
    localparam int WW = cbt_pkg::WGT_W;
    localparam int AW = cbt_pkg::ACC_W;
    localparam int PW = cbt_pkg::PROD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_UU, S_TT, S_W0, S_W1, S_W2, S_W3, S_MAC, S_OUT
    } t_state;

    t_state                       r_state;
    logic [cbt_pkg::LG_W-1:0]     r_cfg_lg;
    logic [cbt_pkg::LG_W-1:0]     r_lg;
    logic [cbt_pkg::IDX_W-1:0]    r_k;
    logic [2:0]                   r_mi;
    logic [2*cbt_pkg::IDX_W:0]    r_uu;
    logic [2*cbt_pkg::IDX_W-1:0]  r_tt;
    logic [WW-1:0]                r_w [4];
    logic [CW-1:0]                r_px [4];
    logic [CW-1:0]                r_py [4];
    logic                         r_o_valid;
    logic [CW-1:0]                r_o_x;
    logic [CW-1:0]                r_o_y;
    logic [cbt_pkg::IDX_W-1:0]    r_o_idx;
    logic                         r_o_last;

    logic [cbt_pkg::UN_W-1:0]     steps;
    logic [cbt_pkg::UN_W-1:0]     un;
    logic                         k_last;
    logic [cbt_pkg::SH_W-1:0]     sh;
    logic [AW-1:0]                half;
    logic [WW-1:0]                mac_a;
    logic [CW-1:0]                mac_b;
    cbt_pkg::t_mac_ctl            mac_ctl;
    logic [PW-1:0]                prod;
    logic [WW-1:0]                prod_w;
    logic [WW-1:0]                prod_w3;
    logic [AW-1:0]                acc_x;
    logic [AW-1:0]                acc_y;
    logic [AW-1:0]                shx;
    logic [AW-1:0]                shy;
    logic                         out_free;
    logic                         in_req;
    logic [cbt_pkg::LG_W-1:0]     lg_eff;

    // sample geometry
    assign steps  = cbt_pkg::UN_W'(1) << r_lg;
    assign un     = steps - cbt_pkg::UN_W'(r_k);
    assign k_last = (r_k == cbt_pkg::IDX_W'(steps - cbt_pkg::UN_W'(1)));
    assign sh     = cbt_pkg::SH_W'({r_lg, 1'b0}) + cbt_pkg::SH_W'(r_lg);
    assign half   = (AW'(1) << sh) >> 1;
    assign lg_eff = (r_cfg_lg > cbt_pkg::MAX_LG) ? cbt_pkg::MAX_LG : r_cfg_lg;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign in_req      = i_valid && o_ready;
    assign out_free    = !r_o_valid || i_ready;

    // operand select for the shared multiplier
    always_comb begin
        mac_a   = '0;
        mac_b   = '0;
        mac_ctl = '0;
        case (r_state)
            S_UU: begin
                mac_a       = WW'(un);
                mac_b       = CW'(un);
                mac_ctl.clr = 1'b1;
            end
            S_TT: begin
                mac_a = WW'(r_k);
                mac_b = CW'(r_k);
            end
            S_W0: begin
                mac_a = WW'(r_uu);
                mac_b = CW'(un);
            end
            S_W1: begin
                mac_a = WW'(r_uu);
                mac_b = CW'(r_k);
            end
            S_W2: begin
                mac_a = WW'(r_tt);
                mac_b = CW'(un);
            end
            S_W3: begin
                mac_a = WW'(r_tt);
                mac_b = CW'(r_k);
            end
            S_MAC: begin
                mac_a         = r_w[r_mi[1:0]];
                mac_b         = r_mi[2] ? r_py[r_mi[1:0]] : r_px[r_mi[1:0]];
                mac_ctl.acc_x = !r_mi[2];
                mac_ctl.acc_y = r_mi[2];
            end
            default: begin
                mac_a = '0;
            end
        endcase
    end

    cbt_mac u_mac (
        .i_clk   (i_clk),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_ctl   (mac_ctl),
        .i_half  (half),
        .o_prod  (prod),
        .o_acc_x (acc_x),
        .o_acc_y (acc_y)
    );

    // weight capture, inner weights carry the factor 3
    assign prod_w  = prod[WW-1:0];
    assign prod_w3 = prod_w + {prod_w[WW-2:0], 1'b0};

    // final rounding shift
    assign shx = acc_x >> sh;
    assign shy = acc_y >> sh;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg_lg  <= cbt_pkg::MAX_LG;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg_lg <= i_cfg_log2_steps;
            end
            // output slot: load a finished point, else drop a taken one
            if (r_state == S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_req) begin
                        // store coordinates in offset binary
                        r_px[0] <= {~i_start_x[CW-1], i_start_x[CW-2:0]};
                        r_py[0] <= {~i_start_y[CW-1], i_start_y[CW-2:0]};
                        r_px[1] <= {~i_out_ctrl_x[CW-1], i_out_ctrl_x[CW-2:0]};
                        r_py[1] <= {~i_out_ctrl_y[CW-1], i_out_ctrl_y[CW-2:0]};
                        r_px[2] <= {~i_in_ctrl_x[CW-1], i_in_ctrl_x[CW-2:0]};
                        r_py[2] <= {~i_in_ctrl_y[CW-1], i_in_ctrl_y[CW-2:0]};
                        r_px[3] <= {~i_end_x[CW-1], i_end_x[CW-2:0]};
                        r_py[3] <= {~i_end_y[CW-1], i_end_y[CW-2:0]};
                        r_lg    <= lg_eff;
                        r_k     <= '0;
                        r_state <= S_UU;
                    end
                end
                S_UU: begin
                    r_uu    <= prod[2*cbt_pkg::IDX_W:0];
                    r_state <= S_TT;
                end
                S_TT: begin
                    r_tt    <= prod[2*cbt_pkg::IDX_W-1:0];
                    r_state <= S_W0;
                end
                S_W0: begin
                    r_w[0]  <= prod_w;
                    r_state <= S_W1;
                end
                S_W1: begin
                    r_w[1]  <= prod_w3;
                    r_state <= S_W2;
                end
                S_W2: begin
                    r_w[2]  <= prod_w3;
                    r_state <= S_W3;
                end
                S_W3: begin
                    r_w[3]  <= prod_w;
                    r_mi    <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_mi <= r_mi + 3'd1;
                    if (r_mi == 3'd7) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait for a free output slot
                    if (out_free) begin
                        r_o_x     <= {~shx[CW-1], shx[CW-2:0]};
                        r_o_y     <= {~shy[CW-1], shy[CW-2:0]};
                        r_o_idx   <= r_k;
                        r_o_last  <= k_last;
                        if (k_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + cbt_pkg::IDX_W'(1);
                            r_state <= S_UU;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_point_x      = r_o_x;
    assign o_point_y      = r_o_y;
    assign o_sample_index = r_o_idx;
    assign o_last_point   = r_o_last;

endmodule

// ===== design/cbt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_checker: port-level checks of the cubic Bezier tessellator
// Watches the handshakes and segment sequencing seen at the top level.
// ----------------------------------------------------------------------------
module cbt_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_ready,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic signed [cbt_pkg::COORD_W-1:0]  o_point_x,
    input  logic                                o_last_point
);

    // a pending point stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_point_x))
        else $error("output request dropped or changed while stalled");

    // a segment request starts work and closes the input
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input still open after segment request");

    // after a point other than the last, the segment is still in progress
    // or its final point is already waiting
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_point |=> !o_ready || o_valid)
        else $error("input opened before final point of segment");

    // reset drops any pending point
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind cubic_bezier_tessellator cbt_checker u_cbt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_point_x    (o_point_x),
    .o_last_point (o_last_point)
);
